FILE: hw/rtl/lcm_pkg.sv
// Package for the load combination matcher: sizes, codes and item types.
// Used by every module of the block; depends on nothing.
package lcm_pkg;

    localparam int LOADS = 7;
    localparam int STATES = 3;
    localparam int DW = $clog2(STATES + 1);
    localparam int LW = $clog2(LOADS + 1);
    localparam int DEPTH = LOADS * STATES;
    localparam int AW = $clog2(DEPTH);
    localparam int PWR_W = 24;
    localparam int PH_W = 16;
    localparam int ENT_W = PWR_W + PH_W;
    localparam int PSUM_W = 27;
    localparam int WSUM_W = 42;
    localparam int DIV_N_W = 43;
    localparam int DIV_D_W = 26;
    localparam int QW = 15;
    localparam int SCORE_W = 17;
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 16;
    localparam int Q15_ONE = 32768;
    localparam int PHASE_LIMIT = 18000;

    localparam logic [DW-1:0] OFF = DW'(STATES);

    typedef enum logic [CFG_IW-1:0] {
        CFG_SCORE_MODE,
        CFG_MIN_SIM,
        CFG_PHASE_CUTOFF,
        CFG_POWER_WEIGHT
    } t_cfg_idx;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_WRITE,
        OP_QSTART,
        OP_CHECK,
        OP_ACC,
        OP_MIX,
        OP_MIXDONE,
        OP_SP,
        OP_SPDONE,
        OP_PH,
        OP_PHDONE,
        OP_MUL1,
        OP_MUL2,
        OP_CMP,
        OP_ADV,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic mode;
        logic combo_ok;
        logic acc_done;
        logic mix_div;
        logic sp_div;
        logic ph_div;
        logic div_done;
        logic last_combo;
    } t_status;

    typedef struct packed {
        logic              cmd;
        logic [2:0]        load_index;
        logic [1:0]        state_index;
        logic              entry_valid;
        logic signed [23:0] entry_power;
        logic signed [15:0] entry_phase;
        logic signed [23:0] measured_power;
        logic signed [15:0] measured_phase;
    } t_in;

    typedef struct packed {
        logic              match_found;
        logic [1:0]        load0_state;
        logic [1:0]        load1_state;
        logic [1:0]        load2_state;
        logic [1:0]        load3_state;
        logic [1:0]        load4_state;
        logic [1:0]        load5_state;
        logic [1:0]        load6_state;
        logic [15:0]       best_similarity;
        logic signed [15:0] mixed_phase;
    } t_out;

endpackage

FILE: hw/rtl/lcm_div.sv
// Shift-subtract divider giving a 15-bit quotient, one bit per cycle.
// Depends on lcm_pkg for its widths.
module lcm_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [lcm_pkg::DIV_N_W-1:0]  i_num,
    input  logic [lcm_pkg::DIV_D_W-1:0]  i_den,
    output logic                         o_done,
    output logic [lcm_pkg::QW-1:0]       o_quo
);
    localparam int CNT_W = $clog2(lcm_pkg::QW);
    localparam int DS_W = lcm_pkg::DIV_D_W + lcm_pkg::QW - 1;

    logic [lcm_pkg::DIV_N_W-1:0] r_rem;
    logic [DS_W-1:0]             r_ds;
    logic [lcm_pkg::QW-1:0]      r_q;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic                        ge;

    assign ge = r_rem >= lcm_pkg::DIV_N_W'(r_ds);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(lcm_pkg::QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_ds  <= {i_den, (lcm_pkg::QW - 1)'(0)};
            r_q   <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - lcm_pkg::DIV_N_W'(r_ds);
            end
            r_q  <= {r_q[lcm_pkg::QW-2:0], ge};
            r_ds <= r_ds >> 1;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

FILE: hw/rtl/lcm_dp.sv
// Datapath: configuration registers, signature store, sums, scoring and result register.
// Depends on lcm_pkg and lcm_div; driven by commands from lcm_ctrl.
module lcm_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lcm_pkg::t_cmd                i_cmd,
    input  lcm_pkg::t_in                 i_in_data,
    input  logic                         i_cfg_we,
    input  logic [lcm_pkg::CFG_IW-1:0]   i_cfg_index,
    input  logic [lcm_pkg::CFG_DW-1:0]   i_cfg_data,
    output lcm_pkg::t_status             o_status,
    output lcm_pkg::t_out                o_out_data
);
    localparam int DW = lcm_pkg::DW;
    localparam int LW = lcm_pkg::LW;
    localparam int AW = lcm_pkg::AW;
    localparam int SW = lcm_pkg::SCORE_W;
    localparam int MW = 2 * lcm_pkg::SCORE_W;
    localparam logic signed [15:0] PH_POS = 16'(lcm_pkg::PHASE_LIMIT);
    localparam logic signed [15:0] PH_NEG = -16'(lcm_pkg::PHASE_LIMIT);

    logic                          r_mode;
    logic [15:0]                   r_min_sim;
    logic [14:0]                   r_cutoff;
    logic [15:0]                   r_pw;

    logic [lcm_pkg::ENT_W-1:0]     r_mem [lcm_pkg::DEPTH];
    logic [lcm_pkg::STATES-1:0]    r_mask [lcm_pkg::LOADS];

    logic signed [23:0]            r_mp;
    logic signed [15:0]            r_mph;
    logic [DW-1:0]                 r_dg [lcm_pkg::LOADS];
    logic [DW-1:0]                 n_dg [lcm_pkg::LOADS];
    logic [LW-1:0]                 r_k;
    logic [lcm_pkg::ENT_W-1:0]     r_rd;
    logic                          r_rd_on;
    logic signed [lcm_pkg::PSUM_W-1:0] r_psum;
    logic signed [lcm_pkg::WSUM_W-1:0] r_wsum;
    logic signed [15:0]            r_mixed;
    logic [SW-1:0]                 r_sp;
    logic [SW-1:0]                 r_sph;
    logic [MW-1:0]                 r_prod;
    logic [SW-1:0]                 r_score;
    logic [SW-1:0]                 r_best;
    logic                          r_found;
    logic [DW-1:0]                 r_best_dg [lcm_pkg::LOADS];
    logic signed [15:0]            r_best_phase;
    lcm_pkg::t_out                 r_out;

    logic [AW-1:0]                 wr_addr;
    logic                          wr_ok;
    logic [DW-1:0]                 dg_k;
    logic [AW-1:0]                 rd_addr;
    logic                          rd_on;
    logic signed [23:0]            rd_power;
    logic signed [15:0]            rd_phase;
    logic signed [lcm_pkg::ENT_W-1:0] rd_prod;
    logic                          combo_ok;
    logic                          last_combo;
    logic                          carry;
    logic                          use_meas;
    logic [lcm_pkg::WSUM_W-1:0]    abs_w;
    logic [lcm_pkg::PSUM_W-1:0]    abs_p;
    logic                          big;
    logic                          mix_neg;
    logic                          mix_div;
    logic [23:0]                   d_p;
    logic signed [lcm_pkg::PSUM_W:0] diff_p;
    logic [lcm_pkg::PSUM_W:0]      e_p;
    logic                          sp_zero;
    logic [15:0]                   d_h;
    logic signed [16:0]            diff_h;
    logic [16:0]                   e_h;
    logic                          ph_zero;
    logic [SW-1:0]                 w_eff;
    logic [SW-1:0]                 w_ph;
    logic [MW-1:0]                 mix_sum;
    logic [SW-1:0]                 cur_score;
    logic [lcm_pkg::QW-1:0]        q_mag;
    logic                          div_start;
    logic [lcm_pkg::DIV_N_W-1:0]   div_num;
    logic [lcm_pkg::DIV_D_W-1:0]   div_den;
    logic                          div_done;
    logic [lcm_pkg::QW-1:0]        div_quo;

    lcm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign wr_addr = AW'(i_in_data.load_index) * AW'(lcm_pkg::STATES)
                   + AW'(i_in_data.state_index);
    assign wr_ok = (32'(i_in_data.load_index) < lcm_pkg::LOADS)
                && (32'(i_in_data.state_index) < lcm_pkg::STATES);

    assign dg_k    = (32'(r_k) < lcm_pkg::LOADS) ? r_dg[r_k] : lcm_pkg::OFF;
    assign rd_on   = (32'(r_k) < lcm_pkg::LOADS) && (dg_k != lcm_pkg::OFF);
    assign rd_addr = AW'(r_k) * AW'(lcm_pkg::STATES) + AW'(dg_k);
    assign rd_power = r_rd[lcm_pkg::ENT_W-1:lcm_pkg::PH_W];
    assign rd_phase = r_rd[lcm_pkg::PH_W-1:0];
    assign rd_prod  = rd_power * rd_phase;

    always_comb begin
        combo_ok   = 1'b1;
        last_combo = 1'b1;
        for (int i = 0; i < lcm_pkg::LOADS; i++) begin
            if (r_dg[i] != lcm_pkg::OFF) begin
                last_combo = 1'b0;
                if (!r_mask[i][r_dg[i]]) begin
                    combo_ok = 1'b0;
                end
            end
        end
    end

    always_comb begin
        carry = 1'b1;
        for (int i = lcm_pkg::LOADS - 1; i >= 0; i--) begin
            n_dg[i] = r_dg[i];
            if (carry) begin
                if (r_dg[i] == lcm_pkg::OFF) begin
                    n_dg[i] = '0;
                end else begin
                    n_dg[i] = r_dg[i] + 1'b1;
                    carry   = 1'b0;
                end
            end
        end
    end

    assign use_meas = $signed({r_mph[15], r_mph}) < $signed({2'b00, r_cutoff});
    assign abs_w    = r_wsum[lcm_pkg::WSUM_W-1] ? lcm_pkg::WSUM_W'(-r_wsum)
                                                 : lcm_pkg::WSUM_W'(r_wsum);
    assign abs_p    = r_psum[lcm_pkg::PSUM_W-1] ? lcm_pkg::PSUM_W'(-r_psum)
                                                 : lcm_pkg::PSUM_W'(r_psum);
    assign big      = abs_w >= {abs_p, lcm_pkg::QW'(0)};
    assign mix_neg  = r_wsum[lcm_pkg::WSUM_W-1] ^ r_psum[lcm_pkg::PSUM_W-1];
    assign mix_div  = !use_meas && (r_psum != '0) && !big;

    assign d_p     = r_mp[23] ? 24'(-r_mp) : 24'(r_mp);
    assign diff_p  = (lcm_pkg::PSUM_W+1)'(r_psum) - (lcm_pkg::PSUM_W+1)'(r_mp);
    assign e_p     = diff_p[lcm_pkg::PSUM_W] ? (lcm_pkg::PSUM_W+1)'(-diff_p)
                                             : (lcm_pkg::PSUM_W+1)'(diff_p);
    assign sp_zero = (d_p == '0) || (e_p >= (lcm_pkg::PSUM_W+1)'(d_p));

    assign d_h     = r_mph[15] ? 16'(-r_mph) : 16'(r_mph);
    assign diff_h  = 17'(r_mixed) - 17'(r_mph);
    assign e_h     = diff_h[16] ? 17'(-diff_h) : 17'(diff_h);
    assign ph_zero = (d_h == '0) || (e_h >= 17'(d_h));

    assign w_eff     = (32'(r_pw) > lcm_pkg::Q15_ONE) ? SW'(lcm_pkg::Q15_ONE) : SW'(r_pw);
    assign w_ph      = SW'(lcm_pkg::Q15_ONE) - w_eff;
    assign mix_sum   = r_prod + MW'(r_sph) * MW'(w_ph);
    assign cur_score = r_mode ? r_score : r_sp;
    assign q_mag     = (32'(div_quo) > lcm_pkg::PHASE_LIMIT) ? lcm_pkg::QW'(lcm_pkg::PHASE_LIMIT)
                                                              : div_quo;

    always_comb begin
        div_start = 1'b0;
        div_num   = lcm_pkg::DIV_N_W'(abs_w);
        div_den   = lcm_pkg::DIV_D_W'(abs_p);
        unique case (i_cmd.op)
            lcm_pkg::OP_MIX: begin
                div_start = mix_div;
            end
            lcm_pkg::OP_SP: begin
                div_start = !sp_zero;
                div_num   = lcm_pkg::DIV_N_W'({e_p, lcm_pkg::QW'(0)});
                div_den   = lcm_pkg::DIV_D_W'(d_p);
            end
            lcm_pkg::OP_PH: begin
                div_start = !ph_zero;
                div_num   = lcm_pkg::DIV_N_W'({e_h, lcm_pkg::QW'(0)});
                div_den   = lcm_pkg::DIV_D_W'(d_h);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= 1'b0;
            r_min_sim <= 16'd26214;
            r_cutoff  <= 15'd2000;
            r_pw      <= 16'd22938;
        end else if (i_cfg_we) begin
            unique case (lcm_pkg::t_cfg_idx'(i_cfg_index))
                lcm_pkg::CFG_SCORE_MODE:   r_mode    <= i_cfg_data[0];
                lcm_pkg::CFG_MIN_SIM:      r_min_sim <= i_cfg_data;
                lcm_pkg::CFG_PHASE_CUTOFF: r_cutoff  <= i_cfg_data[14:0];
                lcm_pkg::CFG_POWER_WEIGHT: r_pw      <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < lcm_pkg::LOADS; i++) begin
                r_mask[i] <= '0;
            end
        end else if (i_cmd.op == lcm_pkg::OP_WRITE && wr_ok) begin
            r_mask[i_in_data.load_index][i_in_data.state_index] <= i_in_data.entry_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == lcm_pkg::OP_WRITE && wr_ok) begin
            r_mem[wr_addr] <= {i_in_data.entry_power, i_in_data.entry_phase};
        end
        if (i_cmd.op == lcm_pkg::OP_ACC && rd_on) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            lcm_pkg::OP_QSTART: begin
                r_mp         <= i_in_data.measured_power;
                r_mph        <= i_in_data.measured_phase;
                r_best       <= SW'(r_min_sim);
                r_found      <= 1'b0;
                r_best_phase <= '0;
                for (int i = 0; i < lcm_pkg::LOADS; i++) begin
                    r_dg[i]      <= '0;
                    r_best_dg[i] <= lcm_pkg::OFF;
                end
            end
            lcm_pkg::OP_CHECK: begin
                r_k     <= '0;
                r_rd_on <= 1'b0;
                r_psum  <= '0;
                r_wsum  <= '0;
            end
            lcm_pkg::OP_ACC: begin
                if (r_rd_on) begin
                    r_psum <= r_psum + lcm_pkg::PSUM_W'(rd_power);
                    r_wsum <= r_wsum + lcm_pkg::WSUM_W'(rd_prod);
                end
                r_rd_on <= rd_on;
                r_k     <= r_k + 1'b1;
            end
            lcm_pkg::OP_MIX: begin
                if (use_meas) begin
                    r_mixed <= r_mph;
                end else if (r_psum == '0) begin
                    r_mixed <= '0;
                end else if (big) begin
                    r_mixed <= mix_neg ? PH_NEG : PH_POS;
                end
            end
            lcm_pkg::OP_MIXDONE: begin
                r_mixed <= mix_neg ? -16'(q_mag) : 16'(q_mag);
            end
            lcm_pkg::OP_SP: begin
                r_sp <= '0;
            end
            lcm_pkg::OP_SPDONE: begin
                r_sp <= SW'(lcm_pkg::Q15_ONE) - SW'(div_quo);
            end
            lcm_pkg::OP_PH: begin
                r_sph <= '0;
            end
            lcm_pkg::OP_PHDONE: begin
                r_sph <= SW'(lcm_pkg::Q15_ONE) - SW'(div_quo);
            end
            lcm_pkg::OP_MUL1: begin
                r_prod <= MW'(r_sp) * MW'(w_eff);
            end
            lcm_pkg::OP_MUL2: begin
                r_score <= mix_sum[SW+14:15];
            end
            lcm_pkg::OP_CMP: begin
                if (cur_score > r_best) begin
                    r_best       <= cur_score;
                    r_found      <= 1'b1;
                    r_best_phase <= r_mixed;
                    for (int i = 0; i < lcm_pkg::LOADS; i++) begin
                        r_best_dg[i] <= r_dg[i];
                    end
                end
            end
            lcm_pkg::OP_ADV: begin
                for (int i = 0; i < lcm_pkg::LOADS; i++) begin
                    r_dg[i] <= n_dg[i];
                end
            end
            lcm_pkg::OP_OUT: begin
                r_out.match_found     <= r_found;
                r_out.load0_state     <= r_best_dg[0][1:0];
                r_out.load1_state     <= r_best_dg[1][1:0];
                r_out.load2_state     <= r_best_dg[2][1:0];
                r_out.load3_state     <= r_best_dg[3][1:0];
                r_out.load4_state     <= r_best_dg[4][1:0];
                r_out.load5_state     <= r_best_dg[5][1:0];
                r_out.load6_state     <= r_best_dg[6][1:0];
                r_out.best_similarity <= r_found ? r_best[15:0] : 16'd0;
                r_out.mixed_phase     <= r_found ? r_best_phase : 16'sd0;
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    assign o_status.mode       = r_mode;
    assign o_status.combo_ok   = combo_ok;
    assign o_status.acc_done   = (r_k == LW'(lcm_pkg::LOADS));
    assign o_status.mix_div    = mix_div;
    assign o_status.sp_div     = !sp_zero;
    assign o_status.ph_div     = !ph_zero;
    assign o_status.div_done   = div_done;
    assign o_status.last_combo = last_combo;
    assign o_out_data          = r_out;

endmodule

FILE: hw/rtl/lcm_ctrl.sv
// Controller state machine: sequences writes, the combination walk and result hand-off.
// Depends on lcm_pkg; commands lcm_dp through a command struct.
module lcm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_in_cmd,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  lcm_pkg::t_status  i_status,
    output lcm_pkg::t_cmd     o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_ACC, S_MIX, S_MIXW, S_SP, S_SPW,
        S_PH, S_PHW, S_MUL1, S_MUL2, S_CMP, S_ADV, S_OUT
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   in_acc;
    logic   out_free;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd.op = lcm_pkg::OP_NONE;
        unique case (r_state)
            S_IDLE:  o_cmd.op = in_acc ? (i_in_cmd ? lcm_pkg::OP_QSTART : lcm_pkg::OP_WRITE)
                                       : lcm_pkg::OP_NONE;
            S_CHECK: o_cmd.op = lcm_pkg::OP_CHECK;
            S_ACC:   o_cmd.op = lcm_pkg::OP_ACC;
            S_MIX:   o_cmd.op = lcm_pkg::OP_MIX;
            S_MIXW:  o_cmd.op = i_status.div_done ? lcm_pkg::OP_MIXDONE : lcm_pkg::OP_NONE;
            S_SP:    o_cmd.op = lcm_pkg::OP_SP;
            S_SPW:   o_cmd.op = i_status.div_done ? lcm_pkg::OP_SPDONE : lcm_pkg::OP_NONE;
            S_PH:    o_cmd.op = lcm_pkg::OP_PH;
            S_PHW:   o_cmd.op = i_status.div_done ? lcm_pkg::OP_PHDONE : lcm_pkg::OP_NONE;
            S_MUL1:  o_cmd.op = lcm_pkg::OP_MUL1;
            S_MUL2:  o_cmd.op = lcm_pkg::OP_MUL2;
            S_CMP:   o_cmd.op = lcm_pkg::OP_CMP;
            S_ADV:   o_cmd.op = lcm_pkg::OP_ADV;
            S_OUT:   o_cmd.op = out_free ? lcm_pkg::OP_OUT : lcm_pkg::OP_NONE;
            default: o_cmd.op = lcm_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && i_in_cmd) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: r_state <= i_status.combo_ok ? S_ACC : S_ADV;
                S_ACC: begin
                    if (i_status.acc_done) begin
                        r_state <= S_MIX;
                    end
                end
                S_MIX: r_state <= i_status.mix_div ? S_MIXW : S_SP;
                S_MIXW: begin
                    if (i_status.div_done) begin
                        r_state <= S_SP;
                    end
                end
                S_SP: begin
                    if (i_status.sp_div) begin
                        r_state <= S_SPW;
                    end else begin
                        r_state <= i_status.mode ? S_PH : S_CMP;
                    end
                end
                S_SPW: begin
                    if (i_status.div_done) begin
                        r_state <= i_status.mode ? S_PH : S_CMP;
                    end
                end
                S_PH: r_state <= i_status.ph_div ? S_PHW : S_MUL1;
                S_PHW: begin
                    if (i_status.div_done) begin
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: r_state <= S_MUL2;
                S_MUL2: r_state <= S_CMP;
                S_CMP:  r_state <= S_ADV;
                S_ADV:  r_state <= i_status.last_combo ? S_OUT : S_CHECK;
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: hw/rtl/load_combination_matcher.sv
// Top level of the load combination matcher: joins controller and datapath.
// Depends on lcm_pkg, lcm_ctrl, lcm_dp and lcm_div.
//
// A write item (cmd 0) stores one load signature. A query
// item (cmd 1) walks all 16384 off/state combinations of the seven loads and
// returns one result item. A combination with an unrecorded state is skipped;
// every other is scored in power-only or in weighted mode, with each division it
// needs (the mixed phase, the power score and, in weighted mode, the phase score)
// done on one shared bit-per-cycle divider. A finished result waits in an output
// register, and the next item is taken while it waits.
module load_combination_matcher (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  lcm_pkg::t_in                i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output lcm_pkg::t_out               o_out_data,
    input  logic                        i_cfg_we,
    input  logic [lcm_pkg::CFG_IW-1:0]  i_cfg_index,
    input  logic [lcm_pkg::CFG_DW-1:0]  i_cfg_data
);
    lcm_pkg::t_cmd    cmd;
    lcm_pkg::t_status status;

    lcm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_cmd    (i_in_data.cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    lcm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_status    (status),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: hw/rtl/lcm_checker.sv
// Port-level checks for the load combination matcher, bound to the top level.
// Depends on lcm_pkg for the item types.
module lcm_assert (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input lcm_pkg::t_in   i_in_data,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input lcm_pkg::t_out  o_out_data
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("Result item changed or dropped before it was taken.");

    a_no_match_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.match_found |->
            o_out_data.best_similarity == 16'd0 && o_out_data.mixed_phase == 16'sd0)
        else $error("A result without a match carries a score or phase.");

    a_score_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.match_found |->
            o_out_data.best_similarity != 16'd0 && o_out_data.best_similarity <= 16'd32768)
        else $error("Matched score is out of range.");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.cmd |=> !o_in_ready)
        else $error("Input taken while a query is in progress.");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Result item shown right after reset.");

endmodule

bind load_combination_matcher lcm_assert u_lcm_checker (.*);

FILE: verif/lcm_checker.sv
// Checker for the load combination matcher: watches the item, result and
// register ports, predicts each query result and compares it. Depends on lcm_pkg.
module lcm_checker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  logic   i_in_ready,
    input  lcm_pkg::t_in  i_in_data,
    input  logic   i_out_valid,
    input  logic   i_out_ready,
    input  lcm_pkg::t_out i_out_data,
    input  logic   i_cfg_we,
    input  logic [lcm_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [lcm_pkg::CFG_DW-1:0] i_cfg_data,
    output int     o_fail_count,
    output int     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic CMD_QUERY = 1'b1;

    logic               weighted_mode;
    logic [15:0]        min_sim;
    logic [14:0]        phase_cutoff;
    logic [15:0]        power_weight;
    logic signed [23:0] sig_power [lcm_pkg::LOADS][lcm_pkg::STATES];
    logic signed [15:0] sig_phase [lcm_pkg::LOADS][lcm_pkg::STATES];
    logic [lcm_pkg::STATES-1:0] recorded [lcm_pkg::LOADS];
    lcm_pkg::t_out      expected_results [$];

    assign o_pending = expected_results.size();

    function automatic longint similarity(longint value, longint ref_val);
        longint d;
        longint e;
        d = ref_val < 0 ? -ref_val : ref_val;
        e = value - ref_val;
        if (e < 0) e = -e;
        if (d == 0 || e >= d) return 0;
        return lcm_pkg::Q15_ONE - (e * lcm_pkg::Q15_ONE) / d;
    endfunction

    function automatic lcm_pkg::t_out match_query(longint meas_pwr, longint meas_ph);
        lcm_pkg::t_out res;
        logic [1:0]  digit [lcm_pkg::LOADS];
        logic [1:0]  best_digit [lcm_pkg::LOADS];
        longint      best;
        longint      best_mix;
        longint      psum;
        longint      wsum;
        longint      mix;
        longint      score;
        longint      w;
        bit          found;
        bit          usable;
        w = power_weight > lcm_pkg::Q15_ONE ? lcm_pkg::Q15_ONE : power_weight;
        best = min_sim;
        best_mix = 0;
        found = 0;
        for (int i = 0; i < lcm_pkg::LOADS; i++) best_digit[i] = lcm_pkg::OFF;
        for (int code = 0; code < 16384; code++) begin
            usable = 1;
            psum = 0;
            wsum = 0;
            for (int i = 0; i < lcm_pkg::LOADS; i++) begin
                digit[i] = 2'((code >> (2 * (lcm_pkg::LOADS - 1 - i))) & 3);
                if (digit[i] != lcm_pkg::OFF) begin
                    if (!recorded[i][digit[i]]) usable = 0;
                    else begin
                        psum += sig_power[i][digit[i]];
                        wsum += longint'(sig_phase[i][digit[i]]) * sig_power[i][digit[i]];
                    end
                end
            end
            if (!usable) continue;
            if (meas_ph < longint'(phase_cutoff)) mix = meas_ph;
            else if (psum == 0) mix = 0;
            else begin
                mix = wsum / psum;
                if (mix > lcm_pkg::PHASE_LIMIT) mix = lcm_pkg::PHASE_LIMIT;
                if (mix < -lcm_pkg::PHASE_LIMIT) mix = -lcm_pkg::PHASE_LIMIT;
            end
            if (weighted_mode)
                score = (similarity(psum, meas_pwr) * w
                         + similarity(mix, meas_ph) * (lcm_pkg::Q15_ONE - w)) >>> 15;
            else
                score = similarity(psum, meas_pwr);
            if (score > best) begin
                best = score;
                found = 1;
                best_mix = mix;
                best_digit = digit;
            end
        end
        res.match_found = found;
        res.load0_state = best_digit[0];
        res.load1_state = best_digit[1];
        res.load2_state = best_digit[2];
        res.load3_state = best_digit[3];
        res.load4_state = best_digit[4];
        res.load5_state = best_digit[5];
        res.load6_state = best_digit[6];
        res.best_similarity = found ? 16'(best) : 16'd0;
        res.mixed_phase = found ? 16'(best_mix) : 16'sd0;
        return res;
    endfunction

    always @(posedge i_clk) begin
        lcm_pkg::t_out exp_res;
        if (!i_rst_n) begin
            weighted_mode <= 1'b0;
            min_sim <= 16'd26214;
            phase_cutoff <= 15'd2000;
            power_weight <= 16'd22938;
            for (int i = 0; i < lcm_pkg::LOADS; i++) recorded[i] <= '0;
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (lcm_pkg::t_cfg_idx'(i_cfg_index))
                    lcm_pkg::CFG_SCORE_MODE: weighted_mode <= i_cfg_data[0];
                    lcm_pkg::CFG_MIN_SIM: min_sim <= i_cfg_data;
                    lcm_pkg::CFG_PHASE_CUTOFF: phase_cutoff <= i_cfg_data[14:0];
                    lcm_pkg::CFG_POWER_WEIGHT: power_weight <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_data.cmd == CMD_QUERY) begin
                    expected_results.push_back(match_query(
                        i_in_data.measured_power, i_in_data.measured_phase));
                end else if (i_in_data.load_index < lcm_pkg::LOADS
                             && i_in_data.state_index < lcm_pkg::STATES) begin
                    sig_power[i_in_data.load_index][i_in_data.state_index]
                        <= i_in_data.entry_power;
                    sig_phase[i_in_data.load_index][i_in_data.state_index]
                        <= i_in_data.entry_phase;
                    recorded[i_in_data.load_index][i_in_data.state_index]
                        <= i_in_data.entry_valid;
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result %p", i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (i_out_data.match_found !== exp_res.match_found
                        || i_out_data.load0_state !== exp_res.load0_state
                        || i_out_data.load1_state !== exp_res.load1_state
                        || i_out_data.load2_state !== exp_res.load2_state
                        || i_out_data.load3_state !== exp_res.load3_state
                        || i_out_data.load4_state !== exp_res.load4_state
                        || i_out_data.load5_state !== exp_res.load5_state
                        || i_out_data.load6_state !== exp_res.load6_state
                        || i_out_data.best_similarity !== exp_res.best_similarity
                        || i_out_data.mixed_phase !== exp_res.mixed_phase) begin
                        if (o_fail_count < 10)
                            $display("mismatch: expected %p got %p", exp_res, i_out_data);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: verif/tb_load_combination_matcher.sv
// Testbench top for the load combination matcher: clock, reset, stimulus,
// register settings and verdict. Depends on lcm_pkg, lcm_checker and the block.
module tb_load_combination_matcher;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;
    localparam int CYCLE_LIMIT = 10000000;
    localparam int LONG_HOLD = 100000;

    logic              i_clk;
    logic              i_rst_n;
    logic              in_valid;
    logic              in_ready;
    lcm_pkg::t_in      in_data;
    logic              out_valid;
    logic              out_ready;
    lcm_pkg::t_out     out_data;
    logic              cfg_we;
    logic [lcm_pkg::CFG_IW-1:0] cfg_index;
    logic [lcm_pkg::CFG_DW-1:0] cfg_data;
    int                fail_count;
    int                pending;
    int                cycles;
    bit                hold_request;

    int                sig_pwr [lcm_pkg::LOADS][lcm_pkg::STATES];
    int                sig_ph [lcm_pkg::LOADS][lcm_pkg::STATES];
    bit                sig_on [lcm_pkg::LOADS][lcm_pkg::STATES];

    load_combination_matcher u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    lcm_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        out_ready = 1'b0;
        forever begin
            if (hold_request) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_request = 0;
            end else begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
                out_ready <= 1'b0;
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(20, 300)) @(posedge i_clk);
                else
                    repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end
        end
    end

    task automatic send_item(input lcm_pkg::t_in item);
        int r;
        r = $urandom_range(0, 99);
        if (r >= 50) begin
            in_valid <= 1'b0;
            repeat (r < 90 ? $urandom_range(1, 4) : $urandom_range(20, 200))
                @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(negedge i_clk);
        while (!in_ready) @(negedge i_clk);
        @(posedge i_clk);
        if (item.cmd == CMD_WRITE && item.load_index < lcm_pkg::LOADS
            && item.state_index < lcm_pkg::STATES) begin
            sig_pwr[item.load_index][item.state_index] = item.entry_power;
            sig_ph[item.load_index][item.state_index] = item.entry_phase;
            sig_on[item.load_index][item.state_index] = item.entry_valid;
        end
    endtask

    function automatic lcm_pkg::t_in signature(int load, int state, bit valid, int pwr, int ph);
        lcm_pkg::t_in item;
        item = '0;
        item.cmd = CMD_WRITE;
        item.load_index = 3'(load);
        item.state_index = 2'(state);
        item.entry_valid = valid;
        item.entry_power = 24'(pwr);
        item.entry_phase = 16'(ph);
        item.measured_power = 24'($urandom);
        item.measured_phase = 16'($urandom);
        return item;
    endfunction

    function automatic lcm_pkg::t_in query(int pwr, int ph);
        lcm_pkg::t_in item;
        item = lcm_pkg::t_in'($bits(lcm_pkg::t_in)'({$urandom, $urandom, $urandom}));
        item.cmd = CMD_QUERY;
        item.measured_power = 24'(pwr);
        item.measured_phase = 16'(ph);
        return item;
    endfunction

    // Few signatures stay recorded so that each query walk stays short.
    function automatic lcm_pkg::t_in random_item();
        int recorded_count;
        int psum;
        int ph;
        int pwr;
        recorded_count = 0;
        psum = 0;
        ph = $urandom_range(0, 36000) - 18000;
        foreach (sig_on[i, s]) begin
            if (sig_on[i][s]) begin
                recorded_count++;
                if ($urandom_range(0, 1) != 0) begin
                    psum += sig_pwr[i][s];
                    ph = sig_ph[i][s];
                end
            end
        end
        if ($urandom_range(0, 99) < 35) begin
            if ($urandom_range(0, 9) == 0)
                return query($urandom, $urandom);
            return query(psum + $urandom_range(0, 400) - 200, ph + $urandom_range(0, 600) - 300);
        end
        pwr = $urandom_range(0, 9) == 0 ? int'($urandom) : $urandom_range(0, 400000) - 200000;
        if ($urandom_range(0, 9) == 0) ph = $urandom;
        return signature($urandom_range(0, 9) == 0 ? 7 : $urandom_range(0, 6),
                         $urandom_range(0, 3),
                         recorded_count < 5 && $urandom_range(0, 3) != 0, pwr, ph);
    endfunction

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic mode, input int min_s, input int cutoff,
                                  input int weight);
        cfg_we <= 1'b1;
        cfg_index <= lcm_pkg::CFG_SCORE_MODE;
        cfg_data <= 16'(mode);
        @(posedge i_clk);
        cfg_index <= lcm_pkg::CFG_MIN_SIM;
        cfg_data <= 16'(min_s);
        @(posedge i_clk);
        cfg_index <= lcm_pkg::CFG_PHASE_CUTOFF;
        cfg_data <= 16'(cutoff);
        @(posedge i_clk);
        cfg_index <= lcm_pkg::CFG_POWER_WEIGHT;
        cfg_data <= 16'(weight);
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        cycles = 0;
        hold_request = 0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = lcm_pkg::CFG_SCORE_MODE;
        cfg_data = '0;
        foreach (sig_on[i, s]) sig_on[i][s] = 0;
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(query(1000, 3000));
        send_item(signature(0, 0, 1, 1000, 3000));
        send_item(signature(1, 1, 1, -8388608, -18000));
        send_item(signature(6, 2, 1, 8388607, 18000));
        send_item(signature(2, 0, 1, 0, 0));
        send_item(signature(7, 3, 1, 5000, 100));
        send_item(signature(3, 3, 1, 5000, 100));
        send_item(query(1000, 3000));
        send_item(query(1000, 500));
        send_item(query(0, 0));
        send_item(query(8388607, 18000));
        send_item(query(-8388608, -18000));
        send_item(query(8389607, 18000));
        send_item(query(1020, -32768));
        send_item(signature(6, 2, 0, 8388607, 18000));
        send_item(signature(5, 1, 1, 2000, -9000));
        send_item(query(3000, 32767));
        send_item(query(8388607, 18000));
        wait_idle();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: apply_settings(1'b1, 0, 0, 32768);
                1: apply_settings(1'b1, 32768, 18000, 0);
                2: apply_settings(1'b0, 20000, 32767, 65535);
                default: apply_settings(1'b1, $urandom_range(10000, 32000),
                                        $urandom_range(0, 18000), $urandom_range(0, 32768));
            endcase
            if (phase == 1) hold_request = 1;
            repeat (25) send_item(random_item());
            wait_idle();
        end
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

FILE: sim.f
hw/rtl/lcm_pkg.sv
hw/rtl/lcm_div.sv
hw/rtl/lcm_dp.sv
hw/rtl/lcm_ctrl.sv
hw/rtl/load_combination_matcher.sv
hw/rtl/lcm_checker.sv
verif/lcm_checker.sv
verif/tb_load_combination_matcher.sv
